[sv/isotp_pkg.sv]
// Shared types and constants for the ISO-TP receive reassembler.
// Used by isotp_front, isotp_jobq, isotp_back and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package isotp_pkg;

	// Result kinds
	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_SEND_FC = 2'd1;
	localparam logic [1:0] KIND_FC_RCVD = 2'd2;
	localparam logic [1:0] KIND_DONE    = 2'd3;

	// Frame types, upper nibble of data byte 0
	localparam logic [3:0] FT_SINGLE      = 4'h0;
	localparam logic [3:0] FT_FIRST       = 4'h1;
	localparam logic [3:0] FT_CONSECUTIVE = 4'h2;
	localparam logic [3:0] FT_FLOW_CTRL   = 4'h3;

	// Configuration register indexes
	localparam logic [1:0] CFG_ACCEPT_ID  = 2'd0;
	localparam logic [1:0] CFG_FC_TX_ID   = 2'd1;
	localparam logic [1:0] CFG_BLOCK_SIZE = 2'd2;
	localparam logic [1:0] CFG_SEP_TIME   = 2'd3;

	localparam logic [28:0] FC_TX_ID_RESET = 29'h18da3df1;
	localparam logic [2:0]  SF_MAX_LEN     = 3'd7;
	localparam logic [2:0]  FF_DATA_BYTES  = 3'd6;

	// Configuration register set
	typedef struct packed {
		logic [28:0] accept_id;
		logic [28:0] fc_tx_id;
		logic [7:0]  block_size;
		logic [7:0]  sep_time;
	} cfg_t;

	// One frame's worth of work for the back end: a run of payload
	// bytes followed by an optional closing result.
	typedef struct packed {
		logic [28:0] msg_id;
		logic [11:0] base_off;
		logic [2:0]  nbytes;
		logic [55:0] data;      // first payload byte in [55:48]
		logic [11:0] total_len;
		logic        tail_en;
		logic [1:0]  tail_kind;
		logic [3:0]  fs;
		logic [7:0]  bs;
		logic [7:0]  st;
		logic [28:0] out_id;
	} job_t;

endpackage

`default_nettype wire

[sv/isotp_front.sv]
// Front end: filters and classifies frames, keeps the reassembly state
// and builds at most one job per frame. Depends on isotp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isotp_front #(
	parameter int MAX_MESSAGE_BYTES = 4095
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire isotp_pkg::cfg_t   cfg,
	input  wire logic              frame_valid,
	input  wire logic [28:0]       frame_id,
	input  wire logic [63:0]       frame_bytes,
	input  wire logic              jq_full,
	output      logic              jq_wr,
	output      isotp_pkg::job_t   jq_data
);

	localparam logic [11:0] MAX_LEN = 12'(MAX_MESSAGE_BYTES);

	logic [28:0] open_id_q;
	logic [11:0] decl_len_q;
	logic [12:0] rcv_cnt_q;
	logic [3:0]  exp_seq_q;
	logic        rx_open_q;

	logic [28:0] open_id_d;
	logic [11:0] decl_len_d;
	logic [12:0] rcv_cnt_d;
	logic [3:0]  exp_seq_d;
	logic        rx_open_d;

	logic        take;
	logic [7:0]  b0, b1, b2;
	logic [3:0]  ftype, low;
	logic [2:0]  sf_len;
	logic [11:0] ff_raw, ff_len;
	logic        ff_short;
	logic [13:0] cf_sum, cf_decl, cf_end;
	logic        has_job;
	isotp_pkg::job_t job;

	assign take  = frame_valid && !jq_full && (frame_id == cfg.accept_id);
	assign b0    = frame_bytes[63:56];
	assign b1    = frame_bytes[55:48];
	assign b2    = frame_bytes[47:40];
	assign ftype = b0[7:4];
	assign low   = b0[3:0];

	// Length decode for single, first and consecutive frames
	assign sf_len   = (low > 4'd7) ? isotp_pkg::SF_MAX_LEN : low[2:0];
	assign ff_raw   = {low, b1};
	assign ff_len   = (ff_raw > MAX_LEN) ? MAX_LEN : ff_raw;
	assign ff_short = ff_len <= 12'd6;
	assign cf_sum   = {1'b0, rcv_cnt_q} + 14'd7;
	assign cf_decl  = {2'b00, decl_len_q};
	assign cf_end   = (cf_sum > cf_decl) ? cf_decl : cf_sum;

	// Classify the frame and build its job
	always_comb begin
		job        = '0;
		has_job    = 1'b0;
		open_id_d  = open_id_q;
		decl_len_d = decl_len_q;
		rcv_cnt_d  = rcv_cnt_q;
		exp_seq_d  = exp_seq_q;
		rx_open_d  = rx_open_q;
		unique case (ftype)
			isotp_pkg::FT_SINGLE: begin
				has_job       = 1'b1;
				rx_open_d     = 1'b0;
				job.msg_id    = frame_id;
				job.nbytes    = sf_len;
				job.data      = frame_bytes[55:0];
				job.total_len = {9'd0, sf_len};
				job.tail_en   = 1'b1;
				job.tail_kind = isotp_pkg::KIND_DONE;
			end
			isotp_pkg::FT_FIRST: begin
				has_job       = 1'b1;
				job.msg_id    = frame_id;
				job.data      = {frame_bytes[47:0], 8'h00};
				job.total_len = ff_len;
				job.tail_en   = 1'b1;
				if (ff_short) begin
					job.nbytes    = ff_len[2:0];
					job.tail_kind = isotp_pkg::KIND_DONE;
					rx_open_d     = 1'b0;
				end else begin
					job.nbytes    = isotp_pkg::FF_DATA_BYTES;
					job.tail_kind = isotp_pkg::KIND_SEND_FC;
					job.bs        = cfg.block_size;
					job.st        = cfg.sep_time;
					job.out_id    = cfg.fc_tx_id;
					open_id_d     = frame_id;
					decl_len_d    = ff_len;
					rcv_cnt_d     = 13'd6;
					exp_seq_d     = 4'd1;
					rx_open_d     = 1'b1;
				end
			end
			isotp_pkg::FT_CONSECUTIVE: begin
				if (rx_open_q && low == exp_seq_q) begin
					has_job       = 1'b1;
					job.msg_id    = open_id_q;
					job.base_off  = rcv_cnt_q[11:0];
					job.nbytes    = 3'(cf_end - {1'b0, rcv_cnt_q});
					job.data      = frame_bytes[55:0];
					job.total_len = decl_len_q;
					job.tail_kind = isotp_pkg::KIND_DONE;
					rcv_cnt_d     = cf_end[12:0];
					exp_seq_d     = exp_seq_q + 4'd1;
					if (cf_end >= cf_decl) begin
						job.tail_en = 1'b1;
						rx_open_d   = 1'b0;
					end
				end
			end
			isotp_pkg::FT_FLOW_CTRL: begin
				has_job       = 1'b1;
				job.msg_id    = frame_id;
				job.tail_en   = 1'b1;
				job.tail_kind = isotp_pkg::KIND_FC_RCVD;
				job.fs        = low;
				job.bs        = b1;
				job.st        = b2;
			end
			default: begin
				has_job = 1'b0;
			end
		endcase
	end

	assign jq_wr   = take && has_job;
	assign jq_data = job;

	// Advance reassembly state on each accepted, matching frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_id_q  <= '0;
			decl_len_q <= '0;
			rcv_cnt_q  <= '0;
			exp_seq_q  <= '0;
			rx_open_q  <= 1'b0;
		end else if (take) begin
			open_id_q  <= open_id_d;
			decl_len_q <= decl_len_d;
			rcv_cnt_q  <= rcv_cnt_d;
			exp_seq_q  <= exp_seq_d;
			rx_open_q  <= rx_open_d;
		end
	end

`ifndef SYNTHESIS
	// An open reception always has bytes left to receive
	a_open_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		rx_open_q |-> ({1'b0, rcv_cnt_q} < {2'b00, decl_len_q}))
		else $error("open reception with no bytes outstanding");

	// A consecutive frame job always carries at least one payload byte
	a_cf_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(jq_wr && ftype == isotp_pkg::FT_CONSECUTIVE) |-> (jq_data.nbytes != 3'd0))
		else $error("consecutive frame job without payload");
`endif

endmodule

`default_nettype wire

[sv/isotp_jobq.sv]
// Two-entry job queue between the front and back ends.
// Depends on isotp_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module isotp_jobq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr,
	input  wire isotp_pkg::job_t wr_data,
	output      logic            full,
	input  wire logic            rd,
	output      isotp_pkg::job_t rd_data,
	output      logic            nonempty
);

	isotp_pkg::job_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            do_wr, do_rd;

	assign full     = count_q == 2'd2;
	assign nonempty = count_q != 2'd0;
	assign do_wr    = wr && !full;
	assign do_rd    = rd && nonempty;
	assign rd_data  = mem_q[rd_ptr_q];

	// Store jobs
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			if (do_wr && !do_rd) count_q <= count_q + 2'd1;
			else if (do_rd && !do_wr) count_q <= count_q - 2'd1;
		end
	end

`ifndef SYNTHESIS
	// The front end never offers a job while the queue is full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && full))
		else $error("job written into a full queue");
`endif

endmodule

`default_nettype wire

[sv/isotp_back.sv]
// Back end: expands each job into results in a single output register,
// one per cycle unless the receiver stalls. Depends on isotp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isotp_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            jq_nonempty,
	input  wire isotp_pkg::job_t jq_data,
	output      logic            jq_rd,
	output      logic            empty,
	input  wire logic            pop,
	output      logic [1:0]      kind,
	output      logic [28:0]     message_id,
	output      logic [11:0]     byte_offset,
	output      logic [7:0]      byte_value,
	output      logic [11:0]     total_length,
	output      logic [3:0]      flow_status,
	output      logic [7:0]      block_size,
	output      logic [7:0]      sep_time,
	output      logic [28:0]     frame_out_id,
	output      logic            last
);

	isotp_pkg::job_t cur_q;
	logic            busy_q;
	logic [2:0]      idx_q;
	logic            out_valid_q;

	logic            emit;
	logic            is_byte;
	logic            last_now;
	logic [7:0]      bsel [8];

	// Split the payload into bytes
	always_comb begin
		for (int k = 0; k < 7; k++) begin
			bsel[k] = cur_q.data[8*(6-k) +: 8];
		end
		bsel[7] = 8'h00;
	end

	assign is_byte  = idx_q < cur_q.nbytes;
	assign last_now = is_byte ? (!cur_q.tail_en && idx_q == cur_q.nbytes - 3'd1) : 1'b1;
	assign emit     = busy_q && (!out_valid_q || pop);
	assign jq_rd    = jq_nonempty && (!busy_q || (emit && last_now));
	assign empty    = !out_valid_q;

	// Load jobs and step through their results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (jq_rd) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 3'd1;
				if (last_now) busy_q <= 1'b0;
			end
			if (emit) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	// Hold the current job
	always_ff @(posedge clk) begin
		if (jq_rd) cur_q <= jq_data;
	end

	// Fill the output register
	always_ff @(posedge clk) begin
		if (emit) begin
			message_id <= cur_q.msg_id;
			total_length <= cur_q.total_len;
			last <= last_now;
			if (is_byte) begin
				kind         <= isotp_pkg::KIND_BYTE;
				byte_offset  <= cur_q.base_off + 12'(idx_q);
				byte_value   <= bsel[idx_q];
				flow_status  <= '0;
				block_size   <= '0;
				sep_time     <= '0;
				frame_out_id <= '0;
			end else begin
				kind         <= cur_q.tail_kind;
				byte_offset  <= '0;
				byte_value   <= '0;
				flow_status  <= cur_q.fs;
				block_size   <= cur_q.bs;
				sep_time     <= cur_q.st;
				frame_out_id <= cur_q.out_id;
			end
		end
	end

`ifndef SYNTHESIS
	// The result index never runs past the closing result of a job
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= cur_q.nbytes))
		else $error("result index beyond job");
`endif

endmodule

`default_nettype wire

[sv/isotp_receive_reassembler.sv]
// ISO-TP receive reassembler, top level: configuration registers and the
// front end, job queue and back end. Depends on isotp_pkg and all isotp_* modules.
//
// Usage:
//  - Frames enter through a queue-like port: a frame is taken at a clock edge
//    with push high and full low. Frames whose identifier differs from
//    accept_id are taken and dropped.
//  - Results leave through a queue-like port: while empty is low the oldest
//    result sits on the result ports; pop high at an edge takes it. The final
//    result of a frame has last set.
//  - Configuration: cfg_valid with cfg_index/cfg_data writes a register
//    (0 accept_id, 1 fc_tx_id, 2 rx_block_size, 3 rx_sep_time); cfg_ready is
//    always high. Write only while no results are outstanding.
//  - Flow: a taken frame passes as a job through the job queue and the back-end
//    current-job register to the output register. A frame yields 1 to 8 results
//    at one per cycle while the receiver does not stall; the front end takes a
//    frame per cycle while the two-entry job queue has room.
//  - Reset: configuration returns to its defaults, no reception is open and
//    both the job queue and output register are empty.
//  - When the receiver stalls, the output register holds, the back end waits,
//    the job queue fills and full rises.
`timescale 1ns / 1ps
`default_nettype none

module isotp_receive_reassembler #(
	parameter int MAX_MESSAGE_BYTES = 4095
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [28:0] cfg_data,
	input  wire logic        push,
	output      logic        full,
	input  wire logic [28:0] frame_id,
	input  wire logic [63:0] frame_bytes,
	output      logic        empty,
	input  wire logic        pop,
	output      logic [1:0]  kind,
	output      logic [28:0] message_id,
	output      logic [11:0] byte_offset,
	output      logic [7:0]  byte_value,
	output      logic [11:0] total_length,
	output      logic [3:0]  flow_status,
	output      logic [7:0]  block_size,
	output      logic [7:0]  sep_time,
	output      logic [28:0] frame_out_id,
	output      logic        last
);

	isotp_pkg::cfg_t cfg_q;
	logic            jq_wr, jq_rd, jq_full, jq_nonempty;
	isotp_pkg::job_t jq_wdata, jq_rdata;

	assign cfg_ready = 1'b1;
	assign full      = jq_full;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accept_id  <= '0;
			cfg_q.fc_tx_id   <= isotp_pkg::FC_TX_ID_RESET;
			cfg_q.block_size <= '0;
			cfg_q.sep_time   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				isotp_pkg::CFG_ACCEPT_ID:  cfg_q.accept_id  <= cfg_data;
				isotp_pkg::CFG_FC_TX_ID:   cfg_q.fc_tx_id   <= cfg_data;
				isotp_pkg::CFG_BLOCK_SIZE: cfg_q.block_size <= cfg_data[7:0];
				isotp_pkg::CFG_SEP_TIME:   cfg_q.sep_time   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	isotp_front #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.frame_valid(push),
		.frame_id   (frame_id),
		.frame_bytes(frame_bytes),
		.jq_full    (jq_full),
		.jq_wr      (jq_wr),
		.jq_data    (jq_wdata)
	);

	isotp_jobq u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (jq_wr),
		.wr_data (jq_wdata),
		.full    (jq_full),
		.rd      (jq_rd),
		.rd_data (jq_rdata),
		.nonempty(jq_nonempty)
	);

	isotp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.jq_nonempty (jq_nonempty),
		.jq_data     (jq_rdata),
		.jq_rd       (jq_rd),
		.empty       (empty),
		.pop         (pop),
		.kind        (kind),
		.message_id  (message_id),
		.byte_offset (byte_offset),
		.byte_value  (byte_value),
		.total_length(total_length),
		.flow_status (flow_status),
		.block_size  (block_size),
		.sep_time    (sep_time),
		.frame_out_id(frame_out_id),
		.last        (last)
	);

endmodule

`default_nettype wire
